FILE: sv/mdo_pkg.sv
// shared types and constants for the motion difference overlay pipeline
package mdo_pkg;

   localparam int unsigned PIX_W   = 8;
   localparam int unsigned ALPHA_W = 9;
   localparam int unsigned DIFF_W  = PIX_W + 1;
   localparam int unsigned PROD_W  = PIX_W + ALPHA_W;
   localparam int unsigned IDX_W   = 8;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(256);
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(128);
   localparam logic [PIX_W-1:0]   THR_RESET   = '0;
   localparam logic [PROD_W-1:0]  ROUND_HALF  = PROD_W'(128);

   // configuration register indexes
   localparam logic [IDX_W-1:0] REG_DEADZONE = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_ALPHA    = IDX_W'(1);

   typedef struct packed {
      logic [PIX_W-1:0]   deadzone_threshold;
      logic [ALPHA_W-1:0] alpha;               // already clamped to 0..256
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } bgr_type;

   // result of the difference stage
   typedef struct packed {
      logic                     motion;
      logic                     neg;
      logic [PIX_W-1:0]         mag;
      logic signed [DIFF_W-1:0] diff;
      bgr_type                  base;
      logic                     eof;
   } diff_type;

endpackage

FILE: sv/mdo_if.sv
// request, response and register write channel interfaces
interface mdo_req_if;
   logic             valid;
   logic             ready;
   logic [7:0]       prev_luma;
   logic [7:0]       curr_luma;
   logic [7:0]       base_blue;
   logic [7:0]       base_green;
   logic [7:0]       base_red;
   logic             end_of_frame;

   modport source (output valid, prev_luma, curr_luma, base_blue, base_green, base_red,
                   end_of_frame, input ready);
   modport sink (input valid, prev_luma, curr_luma, base_blue, base_green, base_red,
                 end_of_frame, output ready);
endinterface

interface mdo_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [8:0] motion_diff;
   logic [7:0]        out_blue;
   logic [7:0]        out_green;
   logic [7:0]        out_red;
   logic              last_pixel;

   modport source (output valid, motion_diff, out_blue, out_green, out_red, last_pixel,
                   input ready);
   modport sink (input valid, motion_diff, out_blue, out_green, out_red, last_pixel,
                 output ready);
endinterface

interface mdo_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [8:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

FILE: sv/mdo_csr.sv
// configuration registers: deadzone threshold and clamped blend alpha
module mdo_csr (
   input  logic             clock,
   input  logic             reset,
   mdo_csr_if.sink          csr_chan,
   output mdo_pkg::cfg_type cfg
);
   import mdo_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;

   // register decode, alpha saturates at full scale
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_DEADZONE: cfg_in.deadzone_threshold = csr_chan.wdata[PIX_W-1:0];
            REG_ALPHA: begin
               cfg_in.alpha = (csr_chan.wdata > ALPHA_ONE) ? ALPHA_ONE : csr_chan.wdata;
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadzone_threshold <= THR_RESET;
         cfg_ff.alpha              <= ALPHA_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/mdo_diff.sv
// first stage: signed luma difference and deadzone
module mdo_diff (
   input  logic              clock,
   input  logic              reset,
   input  mdo_pkg::cfg_type  cfg,
   mdo_req_if.sink           req_chan,
   output logic              diff_valid,
   input  logic              diff_ready,
   output mdo_pkg::diff_type diff_data
);
   import mdo_pkg::*;

   logic                     valid_ff;
   diff_type                 data_ff;
   diff_type                 data_in;
   logic signed [DIFF_W-1:0] delta;
   logic [PIX_W-1:0]         mag;

   assign req_chan.ready = !valid_ff || diff_ready;

   // magnitude and deadzone test
   always_comb begin
      delta = $signed({1'b0, req_chan.curr_luma}) - $signed({1'b0, req_chan.prev_luma});
      mag   = delta[DIFF_W-1] ? PIX_W'(-delta) : delta[PIX_W-1:0];
      data_in.motion     = mag > cfg.deadzone_threshold;
      data_in.neg        = delta[DIFF_W-1];
      data_in.mag        = mag;
      data_in.diff       = data_in.motion ? delta : '0;
      data_in.base.blue  = req_chan.base_blue;
      data_in.base.green = req_chan.base_green;
      data_in.base.red   = req_chan.base_red;
      data_in.eof        = req_chan.end_of_frame;
   end

   // stage valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         data_ff <= data_in;
      end
   end

   assign diff_valid = valid_ff;
   assign diff_data  = data_ff;

endmodule

FILE: sv/mdo_blend.sv
// second and third stages: weighted products, then round and select
module mdo_blend (
   input  logic              clock,
   input  logic              reset,
   input  mdo_pkg::cfg_type  cfg,
   input  logic              diff_valid,
   output logic              diff_ready,
   input  mdo_pkg::diff_type diff_data,
   mdo_rsp_if.source         rsp_chan
);
   import mdo_pkg::*;

   // product stage
   logic                     p_valid_ff;
   logic                     p_ready;
   logic [PROD_W-1:0]        pb_base_ff, pg_base_ff, pr_base_ff, p_ov_ff;
   logic [PROD_W-1:0]        pb_base_in, pg_base_in, pr_base_in, p_ov_in;
   logic                     p_motion_ff, p_neg_ff, p_eof_ff;
   logic signed [DIFF_W-1:0] p_diff_ff;
   bgr_type                  p_base_ff;
   logic [ALPHA_W-1:0]       alpha_inv;

   // output stage
   logic                     o_valid_ff;
   logic                     o_ready;
   logic signed [DIFF_W-1:0] o_diff_ff;
   bgr_type                  o_pix_ff;
   bgr_type                  o_pix_in;
   logic                     o_eof_ff;
   logic [PROD_W-1:0]        sum_b, sum_g, sum_r;

   assign o_ready    = !o_valid_ff || rsp_chan.ready;
   assign p_ready    = !p_valid_ff || o_ready;
   assign diff_ready = p_ready;

   // base and overlay weights, one product each
   always_comb begin
      alpha_inv  = ALPHA_ONE - cfg.alpha;
      pb_base_in = PROD_W'(diff_data.base.blue) * PROD_W'(alpha_inv);
      pg_base_in = PROD_W'(diff_data.base.green) * PROD_W'(alpha_inv);
      pr_base_in = PROD_W'(diff_data.base.red) * PROD_W'(alpha_inv);
      p_ov_in    = PROD_W'(diff_data.mag) * PROD_W'(cfg.alpha);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (p_ready) begin
         p_valid_ff <= diff_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (diff_valid && p_ready) begin
         pb_base_ff  <= pb_base_in;
         pg_base_ff  <= pg_base_in;
         pr_base_ff  <= pr_base_in;
         p_ov_ff     <= p_ov_in;
         p_motion_ff <= diff_data.motion;
         p_neg_ff    <= diff_data.neg;
         p_eof_ff    <= diff_data.eof;
         p_diff_ff   <= diff_data.diff;
         p_base_ff   <= diff_data.base;
      end
   end

   // overlay goes on blue for darker pixels, on red for brighter ones
   always_comb begin
      sum_b = pb_base_ff + (p_neg_ff ? p_ov_ff : '0) + ROUND_HALF;
      sum_g = pg_base_ff + ROUND_HALF;
      sum_r = pr_base_ff + (p_neg_ff ? '0 : p_ov_ff) + ROUND_HALF;
      if (p_motion_ff) begin
         o_pix_in.blue  = sum_b[PROD_W-2 -: PIX_W];
         o_pix_in.green = sum_g[PROD_W-2 -: PIX_W];
         o_pix_in.red   = sum_r[PROD_W-2 -: PIX_W];
      end else begin
         o_pix_in = p_base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_ready) begin
         o_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p_valid_ff && o_ready) begin
         o_pix_ff  <= o_pix_in;
         o_diff_ff <= p_diff_ff;
         o_eof_ff  <= p_eof_ff;
      end
   end

   assign rsp_chan.valid       = o_valid_ff;
   assign rsp_chan.motion_diff = o_diff_ff;
   assign rsp_chan.out_blue    = o_pix_ff.blue;
   assign rsp_chan.out_green   = o_pix_ff.green;
   assign rsp_chan.out_red     = o_pix_ff.red;
   assign rsp_chan.last_pixel  = o_eof_ff;

`ifndef SYNTHESIS
   // a stalled product stage keeps its request
   assert property (@(posedge clock) disable iff (reset)
      p_valid_ff && !o_ready |=> p_valid_ff && $stable(p_ov_ff) && $stable(p_diff_ff))
      else $error("product stage lost a stalled request");

   // a product stage request moves to the output register when it has room
   assert property (@(posedge clock) disable iff (reset)
      p_valid_ff && o_ready |=> o_valid_ff)
      else $error("product stage request dropped");

   // no motion means a zero difference is passed on
   assert property (@(posedge clock) disable iff (reset)
      p_valid_ff && o_ready && !p_motion_ff |=> o_diff_ff == '0)
      else $error("difference not zero on a passed-through pixel");

   // green carries no overlay so it never brightens
   assert property (@(posedge clock) disable iff (reset)
      p_valid_ff && o_ready |=> o_pix_ff.green <= $past(p_base_ff.green))
      else $error("green channel above its base value");
`endif

endmodule

FILE: sv/motion_diff_overlay_pixel.sv
// top level of the per-pixel motion difference overlay pipeline
//
//   channel   direction  handshake      contents
//   req_chan  in         valid/ready    prev/curr luma, base BGR, end of frame
//   rsp_chan  out        valid/ready    motion difference, blended BGR, last pixel
//   csr_chan  in         valid/ready    register index, write data (always ready)
//
// three register stages: difference and deadzone, weight products, round and select
// one request accepted per clock while the output is taken
// the weight multipliers of the product stage set the stage depth
// reset clears all valid bits, threshold to 0 and alpha to 128
// a stall on the response side backs up stage by stage; empty stages still fill
module motion_diff_overlay_pixel (
   input  logic     clock,
   input  logic     reset,
   mdo_req_if.sink  req_chan,
   mdo_rsp_if.source rsp_chan,
   mdo_csr_if.sink  csr_chan
);
   import mdo_pkg::*;

   cfg_type  cfg;
   logic     diff_valid;
   logic     diff_ready;
   diff_type diff_data;

   // configuration registers
   mdo_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // difference stage
   mdo_diff u_diff (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_chan   (req_chan),
      .diff_valid (diff_valid),
      .diff_ready (diff_ready),
      .diff_data  (diff_data)
   );

   // blend stages
   mdo_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .diff_valid (diff_valid),
      .diff_ready (diff_ready),
      .diff_data  (diff_data),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: tb/sv/mdo_overlay_tb_pkg.sv
// pixel types and the overlay checker class for the motion overlay testbench
`timescale 1ns / 1ps
package mdo_overlay_tb_pkg;
   import mdo_pkg::*;

   // one request as offered on the input channel
   typedef struct packed {
      logic [PIX_W-1:0] prev;
      logic [PIX_W-1:0] curr;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic             eof;
   } luma_pixel_type;

   // one blended pixel as seen on the result channel
   typedef struct packed {
      logic signed [DIFF_W-1:0] diff;
      logic [PIX_W-1:0]         blue;
      logic [PIX_W-1:0]         green;
      logic [PIX_W-1:0]         red;
      logic                     last;
   } overlay_pixel_type;

   class overlay_checker;
      logic [PIX_W-1:0]   deadzone;
      logic [ALPHA_W-1:0] alpha;
      overlay_pixel_type  expected_pixels[$];
      int unsigned        mismatches;
      int unsigned        pixels_checked;
      int unsigned        reg_writes;

      function new();
         deadzone       = THR_RESET;
         alpha          = ALPHA_RESET;
         mismatches     = 0;
         pixels_checked = 0;
         reg_writes     = 0;
      endfunction

      // mirror of the register file, unknown indexes are ignored
      function void write_reg(logic [IDX_W-1:0] idx, logic [ALPHA_W-1:0] data);
         reg_writes++;
         case (idx)
            REG_DEADZONE: deadzone = data[PIX_W-1:0];
            REG_ALPHA:    alpha    = data;
            default: ;
         endcase
      endfunction

      // weighted mix of one channel, round half up
      function logic [PIX_W-1:0] mix(int unsigned base, int unsigned tint, int unsigned a);
         return PIX_W'((base * (int'(ALPHA_ONE) - a) + tint * a + int'(ROUND_HALF)) >> 8);
      endfunction

      // deadzoned difference and overlay blend for one pixel
      function overlay_pixel_type blend_pixel(luma_pixel_type p);
         overlay_pixel_type r;
         int unsigned       a;
         int unsigned       mag;
         bit                neg;
         neg = p.curr < p.prev;
         mag = neg ? int'(p.prev) - int'(p.curr) : int'(p.curr) - int'(p.prev);
         a   = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
         if (mag <= deadzone) begin
            mag = 0;
         end
         r.last = p.eof;
         if (mag == 0) begin
            r.diff  = '0;
            r.blue  = p.blue;
            r.green = p.green;
            r.red   = p.red;
         end else begin
            r.diff  = neg ? -DIFF_W'(mag) : DIFF_W'(mag);
            r.blue  = mix(p.blue, neg ? mag : 0, a);
            r.green = mix(p.green, 0, a);
            r.red   = mix(p.red, neg ? 0 : mag, a);
         end
         return r;
      endfunction

      function void add_pixel(luma_pixel_type p);
         expected_pixels.push_back(blend_pixel(p));
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      // compare one result against the oldest pending pixel
      function void check_pixel(overlay_pixel_type got);
         overlay_pixel_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: response with nothing pending, expected none actual diff %0d",
                     $time, int'(got.diff));
            return;
         end
         want = expected_pixels.pop_front();
         pixels_checked++;
         compare_field("motion_diff", int'(want.diff), int'(got.diff));
         compare_field("out_blue", int'(want.blue), int'(got.blue));
         compare_field("out_green", int'(want.green), int'(got.green));
         compare_field("out_red", int'(want.red), int'(got.red));
         compare_field("last_pixel", int'(want.last), int'(got.last));
      endfunction
   endclass

endpackage

FILE: tb/sv/tb_motion_diff_overlay_pixel.sv
// top level testbench of the motion difference overlay pipeline
`timescale 1ns / 1ps
module tb_motion_diff_overlay_pixel;
   import mdo_pkg::*;
   import mdo_overlay_tb_pkg::*;

   localparam int unsigned DRAIN_CYCLES = 4;     // three stages plus margin
   localparam int unsigned HOLD_CYCLES  = 64;
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned PHASE_PIXELS = 110;
   localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(254);

   logic clock = 1'b0;
   logic reset;

   always #2 clock = ~clock;

   mdo_req_if req_chan();
   mdo_rsp_if rsp_chan();
   mdo_csr_if csr_chan();

   motion_diff_overlay_pixel u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   overlay_checker   overlay_sb = new();
   int unsigned      gap_pct = 0;
   int unsigned      stall_pct = 0;
   bit               hold_pending = 1'b0;
   bit               hold_done = 1'b0;
   logic [PIX_W-1:0] cur_thr = THR_RESET;
   int unsigned      quiet_cycles = 0;

   // handshake monitors
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         overlay_sb.add_pixel('{prev: req_chan.prev_luma, curr: req_chan.curr_luma,
                                blue: req_chan.base_blue, green: req_chan.base_green,
                                red: req_chan.base_red, eof: req_chan.end_of_frame});
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         overlay_sb.check_pixel('{diff: rsp_chan.motion_diff, blue: rsp_chan.out_blue,
                                  green: rsp_chan.out_green, red: rsp_chan.out_red,
                                  last: rsp_chan.last_pixel});
      end
      if (!reset && csr_chan.valid && csr_chan.ready) begin
         overlay_sb.write_reg(csr_chan.index, csr_chan.wdata);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d pixels pending", $time,
                  QUIET_LIMIT, overlay_sb.pending());
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side: random stalls and one long hold-off
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_pending && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic luma_pixel_type px(int unsigned prev, int unsigned curr, int unsigned b,
                                         int unsigned g, int unsigned r, int unsigned eof);
      luma_pixel_type p;
      p.prev  = PIX_W'(prev);
      p.curr  = PIX_W'(curr);
      p.blue  = PIX_W'(b);
      p.green = PIX_W'(g);
      p.red   = PIX_W'(r);
      p.eof   = eof[0];
      return p;
   endfunction

   // random pixel, biased towards the deadzone edge, equal luma and the luma and colour extremes
   function automatic luma_pixel_type random_pixel();
      luma_pixel_type   p;
      int unsigned      mode;
      int unsigned      delta;
      logic [PIX_W-1:0] swap;
      p.prev  = PIX_W'($urandom);
      p.curr  = PIX_W'($urandom);
      p.blue  = PIX_W'($urandom);
      p.green = PIX_W'($urandom);
      p.red   = PIX_W'($urandom);
      p.eof   = ($urandom_range(0, 7) == 0);
      mode = $urandom_range(0, 9);
      case (mode) inside
         4: begin
            p.curr = p.prev;
         end
         [5:7]: begin
            delta = cur_thr + $urandom_range(0, 2);
            delta = (delta == 0) ? 0 : delta - 1;
            if (delta > 255) begin
               delta = 255;
            end
            p.prev = PIX_W'($urandom_range(0, 255 - delta));
            p.curr = PIX_W'(p.prev + delta);
            if ($urandom_range(0, 1) == 1) begin
               swap   = p.prev;
               p.prev = p.curr;
               p.curr = swap;
            end
         end
         8: begin
            p.prev = PIX_W'($urandom_range(0, 1) * 255);
            p.curr = PIX_W'($urandom_range(0, 1) * 255);
         end
         9: begin
            p.blue  = PIX_W'($urandom_range(0, 1) * 255);
            p.green = PIX_W'($urandom_range(0, 1) * 255);
            p.red   = PIX_W'($urandom_range(0, 1) * 255);
         end
         default: ;
      endcase
      return p;
   endfunction

   // offer one request, then maybe leave a gap
   task automatic send_pixel(input luma_pixel_type p);
      req_chan.valid        <= 1'b1;
      req_chan.prev_luma    <= p.prev;
      req_chan.curr_luma    <= p.curr;
      req_chan.base_blue    <= p.blue;
      req_chan.base_green   <= p.green;
      req_chan.base_red     <= p.red;
      req_chan.end_of_frame <= p.eof;
      do @(posedge clock); while (!req_chan.ready);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // register write once the pipeline has drained
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ALPHA_W-1:0] data);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (overlay_sb.pending() != 0) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.wdata <= data;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [ALPHA_W-1:0] thr_word,
                            input logic [ALPHA_W-1:0] alpha_word,
                            input int unsigned send_gap, input int unsigned rsp_stall,
                            input int unsigned count);
      write_reg(REG_DEADZONE, thr_word);
      write_reg(REG_ALPHA, alpha_word);
      cur_thr   = thr_word[PIX_W-1:0];
      gap_pct   = send_gap;
      stall_pct = rsp_stall;
      repeat (count) send_pixel(random_pixel());
      req_chan.valid <= 1'b0;
   endtask

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.prev_luma    <= '0;
      req_chan.curr_luma    <= '0;
      req_chan.base_blue    <= '0;
      req_chan.base_green   <= '0;
      req_chan.base_red     <= '0;
      req_chan.end_of_frame <= 1'b0;
      csr_chan.valid        <= 1'b0;
      csr_chan.index        <= '0;
      csr_chan.wdata        <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: full swings, no motion, smallest steps
      send_pixel(px(0, 255, 0, 0, 0, 0));
      send_pixel(px(255, 0, 255, 255, 255, 1));
      send_pixel(px(100, 100, 17, 200, 33, 0));
      send_pixel(px(0, 1, 255, 0, 255, 1));
      send_pixel(px(1, 0, 0, 255, 0, 0));
      send_pixel(px(128, 127, 255, 255, 255, 0));
      send_pixel(px(0, 0, 0, 0, 0, 1));
      send_pixel(px(255, 255, 255, 255, 255, 0));
      req_chan.valid <= 1'b0;

      // deadzone edge, alpha above full scale
      write_reg(REG_DEADZONE, ALPHA_W'(20));
      write_reg(REG_ALPHA, ALPHA_W'(300));
      cur_thr = PIX_W'(20);
      send_pixel(px(50, 70, 90, 91, 92, 0));
      send_pixel(px(50, 71, 90, 91, 92, 1));
      send_pixel(px(70, 50, 90, 91, 92, 0));
      send_pixel(px(71, 50, 90, 91, 92, 0));
      send_pixel(px(0, 255, 255, 255, 255, 1));
      send_pixel(px(200, 100, 0, 0, 0, 0));
      req_chan.valid <= 1'b0;

      // widest deadzone with the top data bit set, zero alpha, a spare index
      write_reg(REG_DEADZONE, ALPHA_W'(511));
      write_reg(REG_ALPHA, ALPHA_W'(0));
      write_reg(REG_SPARE, ALPHA_W'(170));
      cur_thr = PIX_W'(255);
      send_pixel(px(0, 255, 11, 22, 33, 0));
      send_pixel(px(255, 0, 44, 55, 66, 1));
      send_pixel(px(10, 200, 77, 88, 99, 0));
      req_chan.valid <= 1'b0;

      // random phases over a spread of settings and idling
      run_phase(ALPHA_W'(0), ALPHA_W'(0), 30, 30, PHASE_PIXELS);
      run_phase(ALPHA_W'(5), ALPHA_W'(256), 0, 0, PHASE_PIXELS);
      run_phase(ALPHA_W'(255), ALPHA_W'(64), 20, 50, PHASE_PIXELS);
      hold_pending = 1'b1;
      run_phase({1'($urandom_range(0, 1)), 8'($urandom_range(0, 40))},
                ALPHA_W'($urandom_range(0, 511)), 0, 40, PHASE_PIXELS);
      run_phase(ALPHA_W'(1), ALPHA_W'(511), 50, 20, PHASE_PIXELS);
      run_phase({1'($urandom_range(0, 1)), 8'($urandom_range(0, 63))},
                ALPHA_W'($urandom_range(0, 511)), 40, 10, PHASE_PIXELS);
      run_phase(ALPHA_W'(3), ALPHA_W'(128), 0, 0, 60);

      repeat (DRAIN_CYCLES) @(posedge clock);
      while (overlay_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES * 2) @(posedge clock);

      $display("checked %0d pixels across %0d register writes", overlay_sb.pixels_checked,
               overlay_sb.reg_writes);
      $display("deadzone 0 to 255, alpha 0 to 511, one long output hold-off, %0d mismatches",
               overlay_sb.mismatches);
      if (overlay_sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
